// ===== hdl/dwsi_pkg.sv =====
`default_nettype none
package dwsi_pkg;

  // Default sizing of the store
  localparam int DWSI_CAPACITY   = 16;
  localparam int DWSI_VALUE_BITS = 32;

  // Operation codes of a request
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_QUERY      = 3'd5
  } kind_t;

  // Completion codes of a result
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic               is_empty;
    logic [4:0]         element_count;
    logic [1:0]         status;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hdl/dwsi_cmp.sv =====
`default_nettype none
module dwsi_cmp #(
  parameter int VALUE_BITS = dwsi_pkg::DWSI_VALUE_BITS
) (
  input  wire logic [VALUE_BITS-1:0] a,
  input  wire logic [VALUE_BITS-1:0] b,
  output logic                       lt
);
  import dwsi_pkg::*;

  // Signed less-than, shared by every step of the ordered walk
  assign lt = $signed(a) < $signed(b);

endmodule
`default_nettype wire

// ===== hdl/deque_with_sorted_insert.sv =====
`default_nettype none
// Bounded double-ended queue of signed values with an ordered insert. A request is
// taken when start is high and busy is low; busy then stays high until the result
// has been shown. The result is on the result port for exactly one cycle, marked
// by done, and the receiver must take it then: it cannot stall the block. Push,
// pop and query requests go from acceptance through the execute and front-read
// states to done. An ordered insert walks the store one element per cycle through
// a single memory read port and a single shared comparator, then shifts the tail
// one element per cycle. A new request may be offered in the cycle after done.
module deque_with_sorted_insert #(
  parameter int CAPACITY   = dwsi_pkg::DWSI_CAPACITY,
  parameter int VALUE_BITS = dwsi_pkg::DWSI_VALUE_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire dwsi_pkg::req_t cmd,
  output logic               done,
  output dwsi_pkg::rsp_t     result
);
  import dwsi_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = $clog2(2 * CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_PLACE = 7'b0010000,
    S_FRONT = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]      head, head_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      pos, pos_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic [2:0]            kind;
  logic [VALUE_BITS-1:0] val;
  status_t               st, st_next;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data;
  logic [CNT_W-1:0]      rd_off, wr_off;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  we;

  logic [VALUE_BITS-1:0] cmp_a, cmp_b;
  logic                  lt;
  logic                  full, advance;
  logic [63:0]           in_ext;
  logic signed [63:0]    front_ext;
  logic [63:0]           cnt_ext;

  // Ring position of a logical offset from the front
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(off);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  assign full   = (count == CNT_W'(CAPACITY));
  assign in_ext = {32'b0, cmd.value};

  // Share one comparator: the front is checked against the new value, later
  // elements the other way round
  always_comb begin
    if (pos == '0) begin
      cmp_a = val;
      cmp_b = rd_data;
    end else begin
      cmp_a = rd_data;
      cmp_b = val;
    end
  end

  dwsi_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (lt)
  );

  assign advance = (pos == '0) ? !lt : ((pos < count) && lt);

  // Select memory offsets for the current step
  always_comb begin
    rd_off  = '0;
    wr_off  = CNT_W'(CAPACITY - 1);
    wr_data = val;
    we      = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (!full && kind == KIND_PUSH_FRONT) begin
          we = 1'b1;
        end else if (!full && kind == KIND_PUSH_BACK) begin
          we     = 1'b1;
          wr_off = count;
        end
      end
      S_WALK: begin
        rd_off = advance ? pos + 1'b1 : count - 1'b1;
        we     = (pos == '0) && lt;
      end
      S_SHIFT: begin
        rd_off  = idx - CNT_W'(2);
        wr_off  = idx;
        wr_data = rd_data;
        we      = 1'b1;
      end
      S_PLACE: begin
        wr_off = pos;
        we     = 1'b1;
      end
      S_IDLE, S_FRONT, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = slot(head, rd_off);
  assign wr_addr = slot(head, wr_off);

  // Hold the store; read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequence one request
  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    pos_next   = pos;
    idx_next   = idx;
    st_next    = st;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
          st_next    = ST_DONE;
        end
      end
      S_EXEC: begin
        state_next = S_FRONT;
        priority case (kind)
          KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
            if (full) begin
              st_next = ST_FULL;
            end else if (kind == KIND_PUSH_FRONT) begin
              head_next  = slot(head, CNT_W'(CAPACITY - 1));
              count_next = count + 1'b1;
            end else if (kind == KIND_PUSH_BACK) begin
              count_next = count + 1'b1;
            end else if (count == '0) begin
              state_next = S_PLACE;
              pos_next   = '0;
            end else begin
              state_next = S_WALK;
              pos_next   = '0;
            end
          end
          KIND_POP_FRONT: begin
            if (count == '0) begin
              st_next = ST_EMPTY;
            end else begin
              count_next = count - 1'b1;
              head_next  = (count == CNT_W'(1)) ? '0 : slot(head, CNT_W'(1));
            end
          end
          KIND_POP_BACK: begin
            if (count == '0) begin
              st_next = ST_EMPTY;
            end else begin
              count_next = count - 1'b1;
              if (count == CNT_W'(1)) begin
                head_next = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if ((pos == '0) && lt) begin
          // new value goes ahead of the front
          head_next  = slot(head, CNT_W'(CAPACITY - 1));
          count_next = count + 1'b1;
          state_next = S_FRONT;
        end else if (advance) begin
          pos_next = pos + 1'b1;
        end else if (count > pos) begin
          idx_next   = count;
          state_next = S_SHIFT;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_SHIFT: begin
        idx_next = idx - 1'b1;
        if (idx - 1'b1 == pos) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        count_next = count + 1'b1;
        state_next = S_FRONT;
      end
      S_FRONT: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      pos   <= '0;
      idx   <= '0;
      st    <= ST_DONE;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      pos   <= pos_next;
      idx   <= idx_next;
      st    <= st_next;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      kind <= cmd.kind;
      val  <= in_ext[VALUE_BITS-1:0];
    end
  end

  // Drive the result during its single cycle
  assign front_ext = 64'(signed'(rd_data));
  assign cnt_ext   = 64'(count);
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_RESP);

  always_comb begin
    result.front_value   = (count == '0) ? 32'sd0 : front_ext[31:0];
    result.is_empty      = (count == '0);
    result.element_count = cnt_ext[4:0];
    result.status        = st;
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dwsi_pkg::*;

  localparam int CAP = DWSI_CAPACITY;
  // Unused operation codes; the block treats them as a query
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int DRAIN_CYCLES = CAP + 8;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} churn_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t cmd = '0;
  logic busy;
  logic done;
  rsp_t result;

  // Shadow copy of the deque
  logic signed [31:0] shadow_ring [CAP];
  int unsigned shadow_head = 0;
  int unsigned shadow_fill = 0;

  rsp_t expected_results[$];
  int error_count = 0;
  int request_count = 0;
  int checked_count = 0;
  int full_rejects = 0;
  int empty_rejects = 0;
  int insert_count = 0;
  int peak_fill = 0;

  deque_with_sorted_insert uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow deque and return the expected result
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    status_t st;
    int unsigned pos;
    st = ST_DONE;
    case (r.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
        if (shadow_fill >= CAP) begin
          st = ST_FULL;
        end else if (r.kind == KIND_PUSH_BACK) begin
          shadow_ring[(shadow_head + shadow_fill) % CAP] = r.value;
          shadow_fill++;
        end else if (r.kind == KIND_PUSH_FRONT || shadow_fill == 0 ||
                     r.value < shadow_ring[shadow_head]) begin
          shadow_head = (shadow_head + CAP - 1) % CAP;
          shadow_ring[shadow_head] = r.value;
          shadow_fill++;
        end else begin
          // Walk past smaller elements behind the front, then open a slot
          pos = 1;
          while (pos < shadow_fill &&
                 shadow_ring[(shadow_head + pos) % CAP] < r.value)
            pos++;
          for (int unsigned i = shadow_fill; i > pos; i--)
            shadow_ring[(shadow_head + i) % CAP] =
                shadow_ring[(shadow_head + i - 1) % CAP];
          shadow_ring[(shadow_head + pos) % CAP] = r.value;
          shadow_fill++;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % CAP;
          shadow_fill--;
        end
      end
      KIND_POP_BACK: begin
        if (shadow_fill == 0) st = ST_EMPTY;
        else shadow_fill--;
      end
      default: ;
    endcase
    if (shadow_fill == 0) shadow_head = 0;
    res.front_value = (shadow_fill == 0) ? 32'sd0 : shadow_ring[shadow_head];
    res.is_empty = (shadow_fill == 0);
    res.element_count = shadow_fill[4:0];
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < 40)
      $display("ERROR @%0t: %s got 0x%08h, want 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Drive one request and hold it until the block takes it
  task automatic send_request(logic [2:0] kind, logic signed [31:0] value);
    req_t r;
    r.kind = kind;
    r.value = value;
    @(negedge clk);
    start <= 1'b1;
    cmd <= r;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(apply_request(r));
    request_count++;
    if (kind == KIND_INSERT) insert_count++;
    if (expected_results[$].status == ST_FULL) full_rejects++;
    if (expected_results[$].status == ST_EMPTY) empty_rejects++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
  endtask

  task automatic idle_for(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result.front_value, 32'd0);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (result.front_value !== want.front_value)
          report_mismatch("front_value", result.front_value, want.front_value);
        if (result.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(result.is_empty), 32'(want.is_empty));
        if (result.element_count !== want.element_count)
          report_mismatch("element_count", 32'(result.element_count),
                          32'(want.element_count));
        if (result.status !== want.status)
          report_mismatch("status", 32'(result.status), 32'(want.status));
      end
    end
  end

  // Pops and queries on an empty deque, and popping the only element
  task automatic test_empty_store;
    send_request(KIND_POP_FRONT, 32'sd11);
    send_request(KIND_POP_BACK, -32'sd1);
    send_request(KIND_QUERY, 32'sd0);
    send_request(KIND_SPARE_6, 32'sd5);
    send_request(KIND_SPARE_7, -32'sd5);
    send_request(KIND_PUSH_BACK, 32'h8000_0000);
    idle_for(2);
    send_request(KIND_POP_FRONT, 32'sd0);
    send_request(KIND_PUSH_FRONT, 32'h7fff_ffff);
    send_request(KIND_POP_BACK, 32'sd0);
  endtask

  // Ordered insert: into empty, before a greater front, ties, middle, back
  task automatic test_ordered_insert;
    send_request(KIND_INSERT, 32'sd0);
    send_request(KIND_INSERT, -32'sd5);
    send_request(KIND_INSERT, -32'sd5);
    send_request(KIND_INSERT, 32'sd7);
    idle_for(3);
    send_request(KIND_INSERT, 32'sd3);
    send_request(KIND_INSERT, 32'sd7);
    send_request(KIND_INSERT, 32'h8000_0000);
    send_request(KIND_INSERT, 32'h7fff_ffff);
  endtask

  // Fill the deque and push into it while full
  task automatic test_full_store;
    while (shadow_fill < CAP)
      send_request((shadow_fill % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                   $signed($urandom));
    send_request(KIND_PUSH_FRONT, 32'sd1);
    send_request(KIND_PUSH_BACK, 32'sd1);
    send_request(KIND_INSERT, 32'sd1);
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 16)) - 32'sd8;
      5, 6, 7: return $signed($urandom);
      8: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [2:0] random_kind(churn_mode_t mode);
    int pick;
    pick = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (pick < 20) return KIND_PUSH_FRONT;
        if (pick < 40) return KIND_PUSH_BACK;
        if (pick < 85) return KIND_INSERT;
        if (pick < 92) return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        return 3'($urandom_range(KIND_QUERY, KIND_SPARE_7));
      end
      MODE_SHRINK: begin
        if (pick < 40) return KIND_POP_FRONT;
        if (pick < 80) return KIND_POP_BACK;
        if (pick < 92) return KIND_INSERT;
        return 3'($urandom_range(KIND_PUSH_FRONT, KIND_SPARE_7));
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // Random churn in phases that fill, drain or mix, sent in bursts
  task automatic test_random_churn;
    churn_mode_t mode;
    int burst_left;
    int phase_left;
    mode = MODE_GROW;
    burst_left = 0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        mode = churn_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(8, 40);
      end
      if (burst_left == 0) begin
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      send_request(random_kind(mode), random_value());
      burst_left--;
      phase_left--;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_ordered_insert();
    test_full_store();
    test_random_churn();
    idle_for(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d ordered inserts), checked %0d results.",
             request_count, insert_count, checked_count);
    $display("Full rejects %0d, empty rejects %0d, peak fill %0d of %0d.",
             full_rejects, empty_rejects, peak_fill, CAP);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("deque_with_sorted_insert: match");
    end else begin
      $display("deque_with_sorted_insert: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("deque_with_sorted_insert: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dwsi_pkg.sv
hdl/dwsi_cmp.sv
hdl/deque_with_sorted_insert.sv
sim/testbench.sv
